@@ hw/rtl/fxa_pkg.sv @@
// Shared types and opcodes for the fixed-point ALU.
package fxa_pkg;

    localparam int DataW = 32;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_DIV   = 4'd3,
        OP_LT    = 4'd4,
        OP_LE    = 4'd5,
        OP_GT    = 4'd6,
        OP_GE    = 4'd7,
        OP_EQ    = 4'd8,
        OP_NE    = 4'd9,
        OP_INC   = 4'd10,
        OP_DEC   = 4'd11,
        OP_MIN   = 4'd12,
        OP_MAX   = 4'd13,
        OP_TOINT = 4'd14,
        OP_FRINT = 4'd15
    } op_t;

    typedef struct packed {
        op_t          kind;
        logic [31:0]  res;
        logic         cmp;
        logic         sat;
        logic         dz;
        logic         neg;
        logic         ovf;
        logic [63:0]  prod;
        logic [33:0]  rem;
        logic [31:0]  nlow;
        logic [32:0]  den;
        logic [31:0]  quo;
    } payload_t;

endpackage

@@ hw/rtl/fxa_prep.sv @@
// Front stage: decode, simple ops, multiply and divider setup.
module fxa_prep #(
    parameter int FRAC_BITS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [3:0]        kind,
    input  logic [31:0]       operand_a,
    input  logic [31:0]       operand_b,
    output logic              out_valid,
    input  logic              out_ready,
    output fxa_pkg::payload_t out_data
);
    import fxa_pkg::*;

    localparam int NumW = 33 + FRAC_BITS;

    logic            valid_reg;
    payload_t        data_reg;
    payload_t        data_next;
    logic signed [32:0] a_s;
    logic signed [32:0] b_s;
    logic signed [32:0] sum_s;
    logic signed [32:0] dif_s;
    logic signed [32:0] inc_s;
    logic signed [32:0] dec_s;
    logic signed [63:0] shl_s;
    logic [31:0]     mag_a;
    logic [31:0]     mag_b;
    logic [NumW-1:0] num;
    logic [32:0]     den;
    logic            lt;
    logic            eq;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    function automatic logic [31:0] clip33(input logic signed [32:0] v, output logic s);
        logic [31:0] r;
        begin
            s = (v[32] != v[31]);
            if (!s)
                r = v[31:0];
            else if (v[32])
                r = 32'h8000_0000;
            else
                r = 32'h7FFF_FFFF;
            return r;
        end
    endfunction

    always_comb
    begin
        a_s   = {operand_a[31], operand_a};
        b_s   = {operand_b[31], operand_b};
        sum_s = a_s + b_s;
        dif_s = a_s - b_s;
        inc_s = a_s + 33'sd1;
        dec_s = a_s - 33'sd1;
        shl_s = {{32{operand_a[31]}}, operand_a} <<< FRAC_BITS;
        mag_a = operand_a[31] ? (32'd0 - operand_a) : operand_a;
        mag_b = operand_b[31] ? (32'd0 - operand_b) : operand_b;
        lt    = $signed(operand_a) < $signed(operand_b);
        eq    = operand_a == operand_b;
        den   = {mag_b, 1'b0};
        num   = ({{(NumW-32){1'b0}}, mag_a} << (FRAC_BITS + 1))
              + {{(NumW-32){1'b0}}, mag_b};

        data_next      = '0;
        data_next.kind = op_t'(kind);
        data_next.neg  = operand_a[31] ^ operand_b[31];
        data_next.prod = {32'd0, mag_a} * {32'd0, mag_b};
        data_next.den  = den;
        data_next.rem  = {{(34-(FRAC_BITS+1)){1'b0}}, num[NumW-1:32]};
        data_next.nlow = num[31:0];
        data_next.ovf  = {{(34-(FRAC_BITS+1)){1'b0}}, num[NumW-1:32]} >= {1'b0, den};

        case (op_t'(kind))
            OP_ADD:   data_next.res = clip33(sum_s, data_next.sat);
            OP_SUB:   data_next.res = clip33(dif_s, data_next.sat);
            OP_INC:   data_next.res = clip33(inc_s, data_next.sat);
            OP_DEC:   data_next.res = clip33(dec_s, data_next.sat);
            OP_DIV:   data_next.dz  = (operand_b == 32'd0);
            OP_LT:    data_next.cmp = lt;
            OP_LE:    data_next.cmp = lt || eq;
            OP_GT:    data_next.cmp = !lt && !eq;
            OP_GE:    data_next.cmp = !lt;
            OP_EQ:    data_next.cmp = eq;
            OP_NE:    data_next.cmp = !eq;
            OP_MIN:   data_next.res = lt ? operand_a : operand_b;
            OP_MAX:   data_next.res = lt ? operand_b : operand_a;
            OP_TOINT: data_next.res = 32'($signed(operand_a) >>> FRAC_BITS);
            OP_FRINT:
            begin
                if (shl_s > 64'sh7FFF_FFFF)
                begin
                    data_next.res = 32'h7FFF_FFFF;
                    data_next.sat = 1'b1;
                end
                else if (shl_s < -64'sh8000_0000)
                begin
                    data_next.res = 32'h8000_0000;
                    data_next.sat = 1'b1;
                end
                else
                    data_next.res = shl_s[31:0];
            end
            default:  data_next.res = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

@@ hw/rtl/fxa_div_cell.sv @@
// One restoring-divide cell: one quotient bit per cell, payload passes along.
module fxa_div_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  fxa_pkg::payload_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output fxa_pkg::payload_t out_data
);
    import fxa_pkg::*;

    logic        valid_reg;
    payload_t    data_reg;
    payload_t    data_next;
    logic [33:0] rem2;
    logic        ge;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        rem2      = {in_data.rem[32:0], in_data.nlow[31]};
        ge        = rem2 >= {1'b0, in_data.den};
        data_next = in_data;
        data_next.rem  = ge ? (rem2 - {1'b0, in_data.den}) : rem2;
        data_next.nlow = {in_data.nlow[30:0], 1'b0};
        data_next.quo  = {in_data.quo[30:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

@@ hw/rtl/fxa_finish.sv @@
// Last stage: multiply rounding, quotient sign and saturation, output register.
module fxa_finish #(
    parameter int FRAC_BITS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  fxa_pkg::payload_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       result,
    output logic              compare_true,
    output logic              saturated,
    output logic              divide_by_zero
);
    import fxa_pkg::*;

    logic        valid_reg;
    logic [31:0] res_reg;
    logic        cmp_reg;
    logic        sat_reg;
    logic        dz_reg;
    logic [31:0] res_next;
    logic        sat_next;
    logic [63:0] mag;
    logic        big;

    assign in_ready       = !valid_reg || out_ready;
    assign out_valid      = valid_reg;
    assign result         = res_reg;
    assign compare_true   = cmp_reg;
    assign saturated      = sat_reg;
    assign divide_by_zero = dz_reg;

    always_comb
    begin
        res_next = in_data.res;
        sat_next = in_data.sat;
        if (in_data.kind == OP_MUL)
            mag = (in_data.prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        else
            mag = {32'd0, in_data.quo};
        big = in_data.neg ? (mag > 64'h8000_0000) : (mag > 64'h7FFF_FFFF);
        if (in_data.kind == OP_DIV)
            big = big || in_data.ovf;
        if (in_data.kind == OP_MUL || (in_data.kind == OP_DIV && !in_data.dz))
        begin
            sat_next = big;
            if (big)
                res_next = in_data.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            else
                res_next = in_data.neg ? (32'd0 - mag[31:0]) : mag[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            res_reg <= res_next;
            cmp_reg <= in_data.cmp;
            sat_reg <= sat_next;
            dz_reg  <= in_data.dz;
        end
    end

endmodule

@@ hw/rtl/fixed_point_alu_q24_8_unit.sv @@
// Top level of the pipelined fixed-point ALU.
// Signed fixed-point ALU, raw 32-bit operands with FRAC_BITS fraction bits.
// Every operation passes through the same stages from input beat to output beat: one setup
// stage (which also does the 32x32 multiply), a row of 32 divide cells that
// each resolve one quotient bit, and a finishing stage that rounds, saturates
// and holds the output. One beat is accepted per cycle; each stage stalls
// only when it is full and the stage after it cannot take its beat.
module fixed_point_alu_q24_8_unit #(
    parameter int FRAC_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // kind[3:0], operand_a[35:4], operand_b[67:36], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // result[31:0], compare_true, saturated, divide_by_zero, pad
);
    import fxa_pkg::*;

    localparam int Cells = DataW;

    logic        valid_c [Cells+1];
    logic        ready_c [Cells+1];
    payload_t    data_c  [Cells+1];
    logic [31:0] result;
    logic        compare_true;
    logic        saturated;
    logic        divide_by_zero;

    fxa_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .kind      (s_tdata[3:0]),
        .operand_a (s_tdata[35:4]),
        .operand_b (s_tdata[67:36]),
        .out_valid (valid_c[0]),
        .out_ready (ready_c[0]),
        .out_data  (data_c[0])
    );

    for (genvar i = 0; i < Cells; i++)
    begin : g_cell
        fxa_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_c[i]),
            .in_ready  (ready_c[i]),
            .in_data   (data_c[i]),
            .out_valid (valid_c[i+1]),
            .out_ready (ready_c[i+1]),
            .out_data  (data_c[i+1])
        );
    end

    fxa_finish #(.FRAC_BITS(FRAC_BITS)) u_finish (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (valid_c[Cells]),
        .in_ready       (ready_c[Cells]),
        .in_data        (data_c[Cells]),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .result         (result),
        .compare_true   (compare_true),
        .saturated      (saturated),
        .divide_by_zero (divide_by_zero)
    );

    assign m_tdata = {5'd0, divide_by_zero, saturated, compare_true, result};

`ifndef ASSERT_OFF
    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[34] |-> m_tdata[31:0] == 32'd0 && !m_tdata[33] && !m_tdata[32])
        else $error("divide by zero beat malformed");

    a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[32] |-> m_tdata[31:0] == 32'd0 && !m_tdata[33])
        else $error("compare beat malformed");
`endif

endmodule

@@ verif/testbench.sv @@
// Stream testbench for the fixed-point ALU with a scoreboard class and a built-in predictor.
`timescale 1ns / 100ps

module testbench;
    import fxa_pkg::*;

    localparam int FRAC_BITS = 8;
    localparam int LATENCY = 34;
    localparam int RANDOM_BEATS = 1750;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [31:0] result;
        logic        compare_true;
        logic        saturated;
        logic        divide_by_zero;
    } alu_out_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    longint cycle_count = 0;
    bit     stim_done = 1'b0;
    bit     hold_off = 1'b0;

    fixed_point_alu_q24_8_unit #(.FRAC_BITS(FRAC_BITS)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always #1 clk = ~clk;

    function automatic longint clip32(longint v, ref bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic alu_out_t alu_predict(op_t op, logic signed [31:0] a_in,
                                             logic signed [31:0] b_in);
        alu_out_t o;
        longint a, b, r;
        longint unsigned ma, mb, m;
        bit sat, neg;
        a = a_in;
        b = b_in;
        r = 0;
        sat = 1'b0;
        o = '0;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        neg = (a < 0) != (b < 0);
        case (op)
            OP_ADD: r = clip32(a + b, sat);
            OP_SUB: r = clip32(a - b, sat);
            OP_MUL:
            begin
                m = (ma * mb + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                r = clip32(neg ? -longint'(m) : longint'(m), sat);
            end
            OP_DIV:
            begin
                if (b == 0)
                    o.divide_by_zero = 1'b1;
                else
                begin
                    m = (2 * (ma << FRAC_BITS) + mb) / (2 * mb);
                    r = clip32(neg ? -longint'(m) : longint'(m), sat);
                end
            end
            OP_LT:    o.compare_true = a < b;
            OP_LE:    o.compare_true = a <= b;
            OP_GT:    o.compare_true = a > b;
            OP_GE:    o.compare_true = a >= b;
            OP_EQ:    o.compare_true = a == b;
            OP_NE:    o.compare_true = a != b;
            OP_INC:   r = clip32(a + 1, sat);
            OP_DEC:   r = clip32(a - 1, sat);
            OP_MIN:   r = (a < b) ? a : b;
            OP_MAX:   r = (a > b) ? a : b;
            OP_TOINT: r = a >>> FRAC_BITS;
            default:  r = clip32(a * (64'sd1 <<< FRAC_BITS), sat);
        endcase
        o.result = r[31:0];
        o.saturated = sat;
        return o;
    endfunction

    class alu_scoreboard;
        alu_out_t pending[$];
        int errors;

        function void note_beat(logic [71:0] beat);
            pending.push_back(alu_predict(op_t'(beat[3:0]), beat[35:4], beat[67:36]));
        endfunction

        function void check_beat(logic [39:0] beat);
            alu_out_t want, got;
            got.result = beat[31:0];
            got.compare_true = beat[32];
            got.saturated = beat[33];
            got.divide_by_zero = beat[34];
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected beat %h", $time, beat);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (want.result !== got.result)
            begin
                $display("%0t: result exp %h got %h", $time, want.result, got.result);
                errors++;
            end
            if (want.compare_true !== got.compare_true)
            begin
                $display("%0t: compare_true exp %b got %b", $time,
                         want.compare_true, got.compare_true);
                errors++;
            end
            if (want.saturated !== got.saturated)
            begin
                $display("%0t: saturated exp %b got %b", $time,
                         want.saturated, got.saturated);
                errors++;
            end
            if (want.divide_by_zero !== got.divide_by_zero)
            begin
                $display("%0t: divide_by_zero exp %b got %b", $time,
                         want.divide_by_zero, got.divide_by_zero);
                errors++;
            end
        endfunction
    endclass

    alu_scoreboard scoreboard = new();

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && s_tvalid && s_tready)
            scoreboard.note_beat(s_tdata);
        if (rst_n && m_tvalid && m_tready)
            scoreboard.check_beat(m_tdata);
    end

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 3) - 1;
            3: return $signed($urandom_range(0, 1023)) - 512;
            4: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            5: return 32'h7fffffff - $urandom_range(0, 300);
            6: return 32'h80000000 + $urandom_range(0, 300);
            default: return $urandom();
        endcase
    endfunction

    task automatic send_beat(op_t op, logic [31:0] a, logic [31:0] b);
        s_tdata <= {4'b0, b, a, op};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic pause_sender(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic run_directed();
        op_t op;
        logic [31:0] ext[4] = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};
        for (int k = 0; k < 16; k++)
        begin
            op = op_t'(k);
            send_beat(op, ext[k % 4], ext[(k + 1) % 4]);
        end
        send_beat(OP_DIV, 32'h00000300, 32'h0);
        send_beat(OP_INC, 32'h7fffffff, 32'h0);
        send_beat(OP_DEC, 32'h80000000, 32'h0);
        send_beat(OP_MIN, 32'h00000123, 32'h00000123);
        send_beat(OP_MAX, 32'hfffff000, 32'hfffff000);
        send_beat(OP_TOINT, 32'hfffffe01, 32'h0);
        send_beat(OP_FRINT, 32'h00800000, 32'h0);
        send_beat(OP_MUL, 32'h00000180, 32'hffffff80);
        send_beat(OP_DIV, 32'h80000000, 32'h00000001);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int n = 0; n < RANDOM_BEATS; )
        begin
            int burst;
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && n < RANDOM_BEATS; k++, n++)
                send_beat(op_t'($urandom_range(0, 15)), pick_operand(), pick_operand());
            if ($urandom_range(0, 2) != 0)
                pause_sender($urandom_range(1, 6));
        end
        s_tvalid <= 1'b0;
        stim_done <= 1'b1;
    end

    initial
    begin
        repeat (200) @(posedge clk);
        hold_off = 1'b1;
        repeat (150) @(posedge clk);
        hold_off = 1'b0;
    end

    always @(posedge clk)
    begin
        if (hold_off)
            m_tready <= 1'b0;
        else if (cycle_count % 512 < 128)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 3) != 0);
    end

    initial
    begin
        wait (stim_done);
        while (scoreboard.pending.size() != 0 && cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);
        if (cycle_count >= CYCLE_LIMIT)
            $display("Regression FAIL");
        else if (scoreboard.errors == 0 && scoreboard.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end
endmodule
